// File: rtl/core/imurx_pkg.sv
// imurx_pkg: shared types and constants of the imu report frame receiver
// used by imurx_parser and imu_report_frame_receiver_unit, depends on nothing
package imurx_pkg;

    // largest payload length accepted in a frame
    localparam int MAX_PAYLOAD  = 32;
    // payload bytes kept for decoding
    localparam int STORE_DEPTH  = 18;
    localparam int STORE_IDX_W  = $clog2(STORE_DEPTH);
    // report payload lengths
    localparam int FULL_LEN     = 18;
    localparam int ATT_LEN      = 6;
    // frame position counter, holds up to MAX_PAYLOAD + 5
    localparam int COUNT_W      = $clog2(MAX_PAYLOAD + 6);
    localparam int CMP_W        = COUNT_W + 8;

    // frame position codes
    localparam logic [COUNT_W-1:0] CNT_HUNT    = COUNT_W'(0);
    localparam logic [COUNT_W-1:0] CNT_SYNC2   = COUNT_W'(1);
    localparam logic [COUNT_W-1:0] CNT_ID      = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] CNT_CMD     = COUNT_W'(3);
    localparam logic [COUNT_W-1:0] CNT_LEN     = COUNT_W'(4);
    localparam logic [COUNT_W-1:0] CNT_PAYLOAD = COUNT_W'(5);

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_CODE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REPORT_CODE = 2'd3;

    // configuration reset values
    localparam logic [7:0] RST_SYNC_FIRST  = 8'hAA;
    localparam logic [7:0] RST_SYNC_SECOND = 8'h55;
    localparam logic [7:0] RST_ACK_CODE    = 8'h02;
    localparam logic [7:0] RST_REPORT_CODE = 8'h01;

    // result frame kinds
    typedef enum logic [2:0] {
        FK_ACK_MATCH    = 3'd0,
        FK_ACK_MISMATCH = 3'd1,
        FK_FULL_REPORT  = 3'd2,
        FK_ATT_REPORT   = 3'd3,
        FK_BAD_LENGTH   = 3'd4,
        FK_OTHER        = 3'd5
    } t_frame_kind;

    // configuration registers as seen by the parser
    typedef struct packed {
        logic [7:0] sync_first;
        logic [7:0] sync_second;
        logic [7:0] ack_code;
        logic [7:0] report_code;
    } t_cfg;

    // one decoded frame
    typedef struct packed {
        t_frame_kind        frame_kind;
        logic [7:0]         unit_id;
        logic [7:0]         command;
        logic signed [15:0] accel_x;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_z;
        logic signed [15:0] rate_x;
        logic signed [15:0] rate_y;
        logic signed [15:0] rate_z;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic [15:0]        yaw_raw;
    } t_result;

endpackage

// File: rtl/core/imurx_parser.sv
// imurx_parser: frame state tracking, payload store and frame decode
// depends on imurx_pkg
module imurx_parser (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic             i_kind,
    input  logic [7:0]       i_rx_byte,
    input  logic [7:0]       i_sent_cmd,
    input  imurx_pkg::t_cfg  i_cfg,
    output logic             o_res_valid,
    output imurx_pkg::t_result o_res
);

    logic [imurx_pkg::COUNT_W-1:0] r_byte_count, n_byte_count;
    logic [7:0] r_sum, n_sum;
    logic [7:0] r_dev_id, n_dev_id;
    logic [7:0] r_cmd, n_cmd;
    logic [7:0] r_len, n_len;
    logic [7:0] r_expected_ack, n_expected_ack;
    logic [7:0] r_store [imurx_pkg::STORE_DEPTH];
    logic       w_store_we;
    logic [imurx_pkg::COUNT_W-1:0] w_pos;
    logic [imurx_pkg::STORE_IDX_W-1:0] w_store_idx;

    assign w_pos       = r_byte_count - imurx_pkg::CNT_PAYLOAD;
    assign w_store_idx = w_pos[imurx_pkg::STORE_IDX_W-1:0];

    // next state for one accepted transaction
    always_comb begin
        n_byte_count   = r_byte_count;
        n_sum          = r_sum;
        n_dev_id       = r_dev_id;
        n_cmd          = r_cmd;
        n_len          = r_len;
        n_expected_ack = r_expected_ack;
        w_store_we     = 1'b0;
        o_res_valid    = 1'b0;
        if (i_take) begin
            if (i_kind) begin
                n_expected_ack = i_sent_cmd;
            end else begin
                case (r_byte_count)
                    imurx_pkg::CNT_HUNT: begin
                        if (i_rx_byte == i_cfg.sync_first) begin
                            n_byte_count = imurx_pkg::CNT_SYNC2;
                        end
                    end
                    imurx_pkg::CNT_SYNC2: begin
                        n_byte_count = (i_rx_byte == i_cfg.sync_second) ?
                                       imurx_pkg::CNT_ID : imurx_pkg::CNT_HUNT;
                    end
                    imurx_pkg::CNT_ID: begin
                        n_dev_id     = i_rx_byte;
                        n_sum        = i_rx_byte;
                        n_byte_count = imurx_pkg::CNT_CMD;
                    end
                    imurx_pkg::CNT_CMD: begin
                        n_cmd        = i_rx_byte;
                        n_sum        = r_sum + i_rx_byte;
                        n_byte_count = imurx_pkg::CNT_LEN;
                    end
                    imurx_pkg::CNT_LEN: begin
                        // oversize length restarts the hunt
                        if (i_rx_byte > 8'(imurx_pkg::MAX_PAYLOAD)) begin
                            n_byte_count = imurx_pkg::CNT_HUNT;
                        end else begin
                            n_len        = i_rx_byte;
                            n_sum        = r_sum + i_rx_byte;
                            n_byte_count = imurx_pkg::CNT_PAYLOAD;
                        end
                    end
                    default: begin
                        if (imurx_pkg::CMP_W'(w_pos) >= imurx_pkg::CMP_W'(r_len)) begin
                            // sum byte: a good frame gives a result
                            o_res_valid  = (i_rx_byte == r_sum);
                            n_byte_count = imurx_pkg::CNT_HUNT;
                        end else begin
                            w_store_we   = (imurx_pkg::CMP_W'(w_pos) <
                                            imurx_pkg::CMP_W'(imurx_pkg::STORE_DEPTH));
                            n_sum        = r_sum + i_rx_byte;
                            n_byte_count = r_byte_count + imurx_pkg::COUNT_W'(1);
                        end
                    end
                endcase
            end
        end
    end

    // decode of the held frame
    always_comb begin
        o_res            = '0;
        o_res.unit_id    = r_dev_id;
        o_res.command    = r_cmd;
        if (r_cmd == i_cfg.ack_code) begin
            o_res.frame_kind = (r_len != 8'd0 && r_store[0] == r_expected_ack) ?
                               imurx_pkg::FK_ACK_MATCH : imurx_pkg::FK_ACK_MISMATCH;
        end else if (r_cmd == i_cfg.report_code) begin
            if (r_len == 8'(imurx_pkg::FULL_LEN)) begin
                o_res.frame_kind = imurx_pkg::FK_FULL_REPORT;
                o_res.accel_x    = $signed({r_store[1],  r_store[0]});
                o_res.accel_y    = $signed({r_store[3],  r_store[2]});
                o_res.accel_z    = $signed({r_store[5],  r_store[4]});
                o_res.rate_x     = $signed({r_store[7],  r_store[6]});
                o_res.rate_y     = $signed({r_store[9],  r_store[8]});
                o_res.rate_z     = $signed({r_store[11], r_store[10]});
                o_res.pitch      = $signed({r_store[13], r_store[12]});
                o_res.roll       = $signed({r_store[15], r_store[14]});
                o_res.yaw_raw    = {r_store[17], r_store[16]};
            end else if (r_len == 8'(imurx_pkg::ATT_LEN)) begin
                o_res.frame_kind = imurx_pkg::FK_ATT_REPORT;
                o_res.yaw_raw    = {r_store[1], r_store[0]};
                o_res.pitch      = $signed({r_store[3], r_store[2]});
                o_res.roll       = $signed({r_store[5], r_store[4]});
            end else begin
                o_res.frame_kind = imurx_pkg::FK_BAD_LENGTH;
            end
        end else begin
            o_res.frame_kind = imurx_pkg::FK_OTHER;
        end
    end

    // frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count   <= imurx_pkg::CNT_HUNT;
            r_sum          <= '0;
            r_dev_id       <= '0;
            r_cmd          <= '0;
            r_len          <= '0;
            r_expected_ack <= '0;
        end else begin
            r_byte_count   <= n_byte_count;
            r_sum          <= n_sum;
            r_dev_id       <= n_dev_id;
            r_cmd          <= n_cmd;
            r_len          <= n_len;
            r_expected_ack <= n_expected_ack;
        end
    end

    // payload store, no reset
    always_ff @(posedge i_clk) begin
        if (w_store_we) begin
            r_store[w_store_idx] <= i_rx_byte;
        end
    end

endmodule

// File: rtl/core/imu_report_frame_receiver_unit.sv
// imu_report_frame_receiver_unit: top level of the imu report frame receiver
// depends on imurx_pkg and imurx_parser
//
// usage:
//   input channel (i_in_valid / o_in_stall) carries one transaction per byte:
//   i_kind 0 is a received serial byte in i_rx_byte, i_kind 1 records the
//   command just transmitted in i_sent_cmd
//   output channel (o_out_valid / i_out_stall) gives one decoded frame per
//   good frame; bad sums and oversize lengths are dropped without a result
//   config channel (i_cfg_valid / o_cfg_ready) writes sync bytes and command
//   codes; ready is always high, write only while the block is idle
// timing:
//   one input transaction per cycle while o_in_stall is low; a frame result is
//   registered, shown the cycle after its sum byte unless a stalled result
//   holds the output; two entries (result register plus skid) let input go
//   on while a result waits; o_in_stall rises only when both entries are full
// reset:
//   synchronous active low; hunting for sync, registers at default values,
//   no result pending
module imu_report_frame_receiver_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input channel
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_kind,
    input  logic [7:0]                     i_rx_byte,
    input  logic [7:0]                     i_sent_cmd,
    // config channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [imurx_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [7:0]                     i_cfg_data,
    // output channel
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [2:0]                     o_frame_kind,
    output logic [7:0]                     o_unit_id,
    output logic [7:0]                     o_command,
    output logic signed [15:0]             o_accel_x,
    output logic signed [15:0]             o_accel_y,
    output logic signed [15:0]             o_accel_z,
    output logic signed [15:0]             o_rate_x,
    output logic signed [15:0]             o_rate_y,
    output logic signed [15:0]             o_rate_z,
    output logic signed [15:0]             o_pitch,
    output logic signed [15:0]             o_roll,
    output logic [15:0]                    o_yaw_raw
);

    imurx_pkg::t_cfg    r_cfg;
    imurx_pkg::t_result w_res;
    imurx_pkg::t_result r_out, r_skid;
    logic               w_res_valid;
    logic               w_take;
    logic               w_out_fire;
    logic               r_out_valid, r_skid_valid;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign w_take      = i_in_valid && !r_skid_valid;
    assign w_out_fire  = r_out_valid && !i_out_stall;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first  <= imurx_pkg::RST_SYNC_FIRST;
            r_cfg.sync_second <= imurx_pkg::RST_SYNC_SECOND;
            r_cfg.ack_code    <= imurx_pkg::RST_ACK_CODE;
            r_cfg.report_code <= imurx_pkg::RST_REPORT_CODE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                imurx_pkg::REG_SYNC_FIRST:  r_cfg.sync_first  <= i_cfg_data;
                imurx_pkg::REG_SYNC_SECOND: r_cfg.sync_second <= i_cfg_data;
                imurx_pkg::REG_ACK_CODE:    r_cfg.ack_code    <= i_cfg_data;
                imurx_pkg::REG_REPORT_CODE: r_cfg.report_code <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // frame parser and decoder
    imurx_parser u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (w_take),
        .i_kind     (i_kind),
        .i_rx_byte  (i_rx_byte),
        .i_sent_cmd (i_sent_cmd),
        .i_cfg      (r_cfg),
        .o_res_valid(w_res_valid),
        .o_res      (w_res)
    );

    // output and skid valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_out_fire) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_res_valid) begin
            if (r_out_valid && !w_out_fire) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid  <= 1'b1;
            end
        end else if (w_out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    // output and skid payload
    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_out_fire) begin
                r_out <= r_skid;
            end
        end else if (w_res_valid) begin
            if (r_out_valid && !w_out_fire) begin
                r_skid <= w_res;
            end else begin
                r_out  <= w_res;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_frame_kind = r_out.frame_kind;
    assign o_unit_id    = r_out.unit_id;
    assign o_command    = r_out.command;
    assign o_accel_x    = r_out.accel_x;
    assign o_accel_y    = r_out.accel_y;
    assign o_accel_z    = r_out.accel_z;
    assign o_rate_x     = r_out.rate_x;
    assign o_rate_y     = r_out.rate_y;
    assign o_rate_z     = r_out.rate_z;
    assign o_pitch      = r_out.pitch;
    assign o_roll       = r_out.roll;
    assign o_yaw_raw    = r_out.yaw_raw;

    // skid entry only exists behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while the output register is empty");

    // a result arriving at a stalled full output lands in the skid
    a_no_lost_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && w_res_valid && !r_skid_valid) |=> r_skid_valid)
        else $error("result dropped at a stalled output");

    // skid entry stays while the output is stalled
    a_skid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_stall) |=> r_skid_valid)
        else $error("skid entry lost while output stalled");

endmodule
